@@ rtl/core/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int CodeWidth = 32;
  localparam int LenWidth = 6;
  localparam int MaxCodeLength = 32;
  localparam int TableDepth = 256;
  localparam int QueueDepth = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);

  localparam logic [1:0] ActLoad = 2'd0;
  localparam logic [1:0] ActEncode = 2'd1;
  localparam logic [1:0] ActFinish = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
    logic [CodeWidth-1:0] code_bits;
    logic [LenWidth-1:0] code_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic is_count;
    logic last;
  } result_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic [LenWidth-1:0] len;
  } entry_t;

  typedef struct packed {
    logic is_finish;
    entry_t entry;
  } job_t;

endpackage

@@ rtl/core/huffman_code_table_bit_packer_top.sv @@
// An item's first result byte passes the lookup register, queue, packer work register and
// output register. One item per cycle enters unless full; the packer emits one byte per
// cycle unless a result waits unpopped, up to four per encode and two per finish.
// A four-entry queue between the table lookup and the packer absorbs bursts.
// Reset is synchronous and clears the packer, the queue and all valid flags;
// the code table is not cleared and an entry must be loaded before it is encoded.
module huffman_code_table_bit_packer_top (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  hcbp_pkg::item_t item,
  output logic empty,
  input  logic pop,
  output hcbp_pkg::result_t result
);

  logic q_wr_valid;
  logic q_wr_ready;
  hcbp_pkg::job_t q_wr_data;
  logic q_rd_valid;
  logic q_rd_take;
  hcbp_pkg::job_t q_rd_data;

  hcbp_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .job_valid(q_wr_valid),
    .job_ready(q_wr_ready),
    .job(q_wr_data)
  );

  hcbp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_valid(q_wr_valid),
    .wr_ready(q_wr_ready),
    .wr_data(q_wr_data),
    .rd_valid(q_rd_valid),
    .rd_take(q_rd_take),
    .rd_data(q_rd_data)
  );

  hcbp_back u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(q_rd_valid),
    .job_take(q_rd_take),
    .job(q_rd_data),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule

@@ rtl/core/hcbp_front.sv @@
module hcbp_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  hcbp_pkg::item_t item,
  output logic job_valid,
  input  logic job_ready,
  output hcbp_pkg::job_t job
);

  hcbp_pkg::entry_t code_table [hcbp_pkg::TableDepth];
  hcbp_pkg::entry_t rd_entry;
  hcbp_pkg::entry_t wr_entry;
  logic s1_valid;
  logic s1_finish;
  logic accept;
  logic is_job;

  assign full = s1_valid && !job_ready;
  assign accept = push && !full;
  assign is_job = (item.action == hcbp_pkg::ActEncode) || (item.action == hcbp_pkg::ActFinish);

  always_comb begin
    wr_entry.code = item.code_bits;
    if (item.code_length > hcbp_pkg::LenWidth'(hcbp_pkg::MaxCodeLength)) begin
      wr_entry.len = hcbp_pkg::LenWidth'(hcbp_pkg::MaxCodeLength);
    end else begin
      wr_entry.len = item.code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.action == hcbp_pkg::ActLoad) begin
      code_table[item.symbol] <= wr_entry;
    end
    if (accept) begin
      rd_entry <= code_table[item.symbol];
      s1_finish <= (item.action == hcbp_pkg::ActFinish);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_job;
    end else if (job_ready) begin
      s1_valid <= 1'b0;
    end
  end

  assign job_valid = s1_valid;
  assign job.is_finish = s1_finish;
  assign job.entry = rd_entry;

endmodule

@@ rtl/core/hcbp_queue.sv @@
module hcbp_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  hcbp_pkg::job_t wr_data,
  output logic rd_valid,
  input  logic rd_take,
  output hcbp_pkg::job_t rd_data
);

  hcbp_pkg::job_t slots [hcbp_pkg::QueueDepth];
  logic [hcbp_pkg::QueuePtrWidth-1:0] wr_ptr;
  logic [hcbp_pkg::QueuePtrWidth-1:0] rd_ptr;
  logic [hcbp_pkg::QueuePtrWidth:0] count;
  logic do_wr;
  logic do_rd;

  assign wr_ready = (count != (hcbp_pkg::QueuePtrWidth+1)'(hcbp_pkg::QueueDepth));
  assign rd_valid = (count != '0);
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_take && rd_valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/hcbp_back.sv @@
module hcbp_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_take,
  input  hcbp_pkg::job_t job,
  output logic empty,
  input  logic pop,
  output hcbp_pkg::result_t result
);

  logic [7:0] pend;
  logic [3:0] fill;
  logic wk_valid;
  logic wk_finish;
  logic [39:0] wk_word;
  logic [2:0] wk_n;
  logic [2:0] wk_idx;
  logic out_valid;
  hcbp_pkg::result_t out_data;

  logic [32:0] mask;
  logic [31:0] code_m;
  logic [5:0] total;
  logic [5:0] shamt;
  logic [39:0] acc;
  logic [2:0] n;
  logic [5:0] fill_next;
  logic [7:0] pend_next;
  logic emit;
  logic wk_last;
  logic out_pop;

  always_comb begin
    mask = (33'd1 << job.entry.len) - 33'd1;
    code_m = job.entry.code & mask[31:0];
    total = {2'b00, fill} + job.entry.len;
    shamt = 6'd40 - total;
    acc = {pend, 32'b0} | ({8'b0, code_m} << shamt);
    priority if (total == 6'd0) begin
      n = 3'd0;
    end else if (job.entry.len == '0 && fill == 4'd8) begin
      n = 3'd1;
    end else begin
      n = 3'((total - 6'd1) >> 3);
    end
    fill_next = total - {n, 3'b000};
    pend_next = acc[{3'd4 - n, 3'b000} +: 8];
  end

  assign out_pop = pop && out_valid;
  assign emit = wk_valid && (!out_valid || out_pop);
  assign wk_last = (wk_idx == wk_n - 3'd1);
  assign job_take = job_valid && (!wk_valid || (emit && wk_last));
  assign empty = !out_valid;
  assign result = out_data;

  always_ff @(posedge clk) begin
    if (job_take) begin
      wk_idx <= '0;
      wk_finish <= job.is_finish;
      if (job.is_finish) begin
        wk_word <= {pend, 8'd8 - {4'b0000, fill}, 24'b0};
        wk_n <= 3'd2;
      end else begin
        wk_word <= acc;
        wk_n <= n;
      end
    end else if (emit) begin
      wk_idx <= wk_idx + 3'd1;
    end
    if (emit) begin
      out_data.out_byte <= wk_word[{3'd4 - wk_idx, 3'b000} +: 8];
      out_data.is_count <= wk_finish && (wk_idx == 3'd1);
      out_data.last <= wk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      fill <= '0;
      wk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        if (job.is_finish) begin
          pend <= '0;
          fill <= '0;
          wk_valid <= 1'b1;
        end else begin
          pend <= pend_next;
          fill <= fill_next[3:0];
          wk_valid <= (n != 3'd0);
        end
      end else if (emit && wk_last) begin
        wk_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/hcbp_checker.sv @@
module hcbp_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input hcbp_pkg::result_t result
);

  property p_hold_stalled;
    @(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(result));
  endproperty
  a_hold_stalled: assert property (p_hold_stalled) else $error("stalled result changed");

  property p_count_is_last;
    @(posedge clk) disable iff (rst)
      (!empty && result.is_count) |-> result.last;
  endproperty
  a_count_is_last: assert property (p_count_is_last) else $error("count byte not last");

  property p_count_range;
    @(posedge clk) disable iff (rst)
      (!empty && result.is_count) |-> (result.out_byte <= 8'd8);
  endproperty
  a_count_range: assert property (p_count_range) else $error("count byte out of range");

  property p_no_double_count;
    @(posedge clk) disable iff (rst)
      (!empty && pop && result.is_count) |=> !(!empty && result.is_count);
  endproperty
  a_no_double_count: assert property (p_no_double_count)
    else $error("count byte follows count byte");

endmodule

bind huffman_code_table_bit_packer_top hcbp_checker u_hcbp_checker (
  .clk(clk),
  .rst(rst),
  .empty(empty),
  .pop(pop),
  .result(result)
);
